// File: rtl/swb_pkg.sv
// Shared types and timing constants for the single-wire bus master.
`default_nettype none
package swb_pkg;

   // Command codes carried in func
   localparam logic [2:0] FUNC_RESET      = 3'd0;
   localparam logic [2:0] FUNC_READ_BIT   = 3'd1;
   localparam logic [2:0] FUNC_WRITE_BIT  = 3'd2;
   localparam logic [2:0] FUNC_READ_BYTE  = 3'd3;
   localparam logic [2:0] FUNC_WRITE_BYTE = 3'd4;
   localparam logic [2:0] FUNC_START_STOP = 3'd5;

   // Line mode register codes
   localparam logic [1:0] MODE_ONE_WIRE = 2'd0;
   localparam logic [1:0] MODE_SINGLE   = 2'd1;
   localparam logic [1:0] MODE_SIO      = 2'd2;

   // Phase lengths in ticks
   localparam logic [9:0] LEN_OW_RST      = 10'd480;
   localparam logic [9:0] LEN_OW_RD_LOW   = 10'd6;
   localparam logic [9:0] LEN_OW_RD_REL   = 10'd61;
   localparam logic [9:0] LEN_OW_WR1_LOW  = 10'd6;
   localparam logic [9:0] LEN_OW_WR0_LOW  = 10'd60;
   localparam logic [9:0] LEN_OW_WR1_REL  = 10'd64;
   localparam logic [9:0] LEN_OW_WR0_REL  = 10'd10;
   localparam logic [9:0] LEN_SIO_RST     = 10'd480;
   localparam logic [9:0] LEN_SIO_RST_REL = 10'd10;
   localparam logic [9:0] LEN_SIO_LOW2    = 10'd2;
   localparam logic [9:0] LEN_SIO_REL2    = 10'd3;
   localparam logic [9:0] LEN_SIO_SS      = 10'd150;
   localparam logic [9:0] LEN_SIO_SHORT   = 10'd1;
   localparam logic [9:0] LEN_SIO_W0_LOW  = 10'd6;
   localparam logic [9:0] LEN_SIO_RD_REL  = 10'd10;
   localparam logic [9:0] LEN_SIO_W1_REL  = 10'd12;
   localparam logic [9:0] LEN_SIO_W0_REL  = 10'd7;
   localparam logic [9:0] LEN_ONE         = 10'd1;

   // Sample points inside release phases
   localparam logic [8:0] SAMPLE_OW_RST  = 9'd70;
   localparam logic [8:0] SAMPLE_OW_RD   = 9'd6;
   localparam logic [8:0] SAMPLE_SIO_RST = 9'd2;

   // Slot counts and byte boundary
   localparam logic [3:0] SLOTS_BYTE = 4'd9;
   localparam logic [3:0] SLOTS_BIT  = 4'd1;
   localparam logic [3:0] BITS_BYTE  = 4'd8;

   typedef enum logic [3:0] {
      PH_IDLE         = 4'd0,
      PH_OW_RST_LOW   = 4'd1,
      PH_OW_RST_REL   = 4'd2,
      PH_OW_RD_LOW    = 4'd3,
      PH_OW_RD_REL    = 4'd4,
      PH_OW_WR_LOW    = 4'd5,
      PH_OW_WR_REL    = 4'd6,
      PH_SIO_RST_LOW  = 4'd7,
      PH_SIO_RST_REL  = 4'd8,
      PH_SIO_RST_LOW2 = 4'd9,
      PH_SIO_RST_REL2 = 4'd10,
      PH_SIO_SS       = 4'd11,
      PH_SIO_BIT_LOW  = 4'd12,
      PH_SIO_BIT_REL  = 4'd13
   } phase_type;

   typedef struct packed {
      logic       start_req;
      logic [2:0] func;
      logic [7:0] data_in;
      logic       last_byte;
      logic       line_level;
   } req_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       flag;
      logic [7:0] data_out;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/swb_req_reg.sv
// Input register stage: holds one accepted tick item until the engine takes it.
`default_nettype none
module swb_req_reg
   import swb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire req_type req_item,
   output logic         req_stall,
   input  wire logic    take,
   output logic         hold_valid,
   output req_type      hold_item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    load;

   // Stall only when full and the held item is not leaving
   assign req_stall = valid_ff & ~take;
   assign load      = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule
`default_nettype wire

// File: rtl/swb_engine.sv
// Bus waveform engine: phase state and per-tick result logic.
`default_nettype none
module swb_engine
   import swb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire req_type    item,
   input  wire logic [1:0] line_mode,
   output rsp_type         result
);

   phase_type  phase_ff, phase_in;
   logic [8:0] tick_ff, tick_in;
   logic [7:0] shift_ff, shift_in;
   logic [3:0] bit_ff, bit_in;
   logic [2:0] cmd_ff, cmd_in;
   logic       samp_ff, samp_in;
   logic       nack_ff, nack_in;

   // Working values after a possible command start
   phase_type  cur_phase;
   logic [8:0] cur_tick;
   logic [7:0] cur_shift;
   logic [3:0] cur_bit;
   logic [2:0] cur_cmd;
   logic       cur_nack;
   logic       cur_samp;
   logic       no_work;
   logic       immediate;

   logic       slot_read;
   logic       slot_val;
   logic [9:0] len;
   logic [9:0] tick_next;
   logic       phase_end;
   logic [3:0] bit_next;
   logic [3:0] slots;
   logic       done;
   logic       drives;

   // Start a command when idle
   always_comb begin
      cur_phase = phase_ff;
      cur_tick  = tick_ff;
      cur_shift = shift_ff;
      cur_bit   = bit_ff;
      cur_cmd   = cmd_ff;
      cur_nack  = nack_ff;
      cur_samp  = samp_ff;
      no_work   = 1'b0;
      immediate = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (!item.start_req) begin
            no_work = 1'b1;
         end else begin
            cur_cmd   = item.func;
            cur_tick  = '0;
            cur_bit   = '0;
            cur_samp  = 1'b0;
            cur_shift = '0;
            if (line_mode == MODE_ONE_WIRE) begin
               case (item.func)
                  FUNC_RESET:     cur_phase = PH_OW_RST_LOW;
                  FUNC_READ_BIT:  cur_phase = PH_OW_RD_LOW;
                  FUNC_WRITE_BIT: begin
                     cur_phase = PH_OW_WR_LOW;
                     cur_shift = {7'd0, item.data_in[0]};
                  end
                  default:        cur_phase = PH_IDLE;
               endcase
            end else if (line_mode == MODE_SIO) begin
               case (item.func)
                  FUNC_RESET:      cur_phase = PH_SIO_RST_LOW;
                  FUNC_READ_BIT:   cur_phase = PH_SIO_BIT_LOW;
                  FUNC_WRITE_BIT:  begin
                     cur_phase = PH_SIO_BIT_LOW;
                     cur_shift = {7'd0, item.data_in[0]};
                  end
                  FUNC_READ_BYTE:  begin
                     cur_phase = PH_SIO_BIT_LOW;
                     cur_nack  = item.last_byte;
                  end
                  FUNC_WRITE_BYTE: begin
                     cur_phase = PH_SIO_BIT_LOW;
                     cur_shift = item.data_in;
                  end
                  FUNC_START_STOP: cur_phase = PH_SIO_SS;
                  default:         cur_phase = PH_IDLE;
               endcase
            end else begin
               cur_phase = PH_IDLE;
            end
            immediate = (cur_phase == PH_IDLE);
         end
      end
   end

   // Slot kind and slot bit for SIO bit slots
   always_comb begin
      slot_read = (cur_cmd == FUNC_READ_BIT) ||
                  (cur_cmd == FUNC_READ_BYTE && cur_bit < BITS_BYTE) ||
                  (cur_cmd == FUNC_WRITE_BYTE && cur_bit >= BITS_BYTE);
      case (cur_cmd)
         FUNC_WRITE_BIT:  slot_val = cur_shift[0];
         FUNC_READ_BYTE:  slot_val = cur_nack;
         FUNC_WRITE_BYTE: slot_val = (cur_bit < BITS_BYTE) ? cur_shift[~cur_bit[2:0]] : 1'b0;
         default:         slot_val = 1'b0;
      endcase
      slots = (cur_cmd == FUNC_READ_BYTE || cur_cmd == FUNC_WRITE_BYTE) ? SLOTS_BYTE
                                                                         : SLOTS_BIT;
   end

   // Sample the line at fixed points
   always_comb begin
      samp_in  = cur_samp;
      shift_in = cur_shift;
      if ((cur_phase == PH_OW_RST_REL && cur_tick == SAMPLE_OW_RST) ||
          (cur_phase == PH_OW_RD_REL && cur_tick == SAMPLE_OW_RD) ||
          (cur_phase == PH_SIO_RST_REL2 && cur_tick == SAMPLE_SIO_RST)) begin
         samp_in = item.line_level;
      end else if (cur_phase == PH_SIO_BIT_REL && cur_tick == '0 && slot_read) begin
         samp_in = item.line_level;
         if (cur_cmd == FUNC_READ_BYTE && cur_bit < BITS_BYTE) begin
            shift_in = {cur_shift[6:0], item.line_level};
         end
      end
   end

   // Length of the current phase
   always_comb begin
      case (cur_phase)
         PH_OW_RST_LOW:   len = LEN_OW_RST;
         PH_OW_RST_REL:   len = LEN_OW_RST;
         PH_OW_RD_LOW:    len = LEN_OW_RD_LOW;
         PH_OW_RD_REL:    len = LEN_OW_RD_REL;
         PH_OW_WR_LOW:    len = shift_in[0] ? LEN_OW_WR1_LOW : LEN_OW_WR0_LOW;
         PH_OW_WR_REL:    len = shift_in[0] ? LEN_OW_WR1_REL : LEN_OW_WR0_REL;
         PH_SIO_RST_LOW:  len = LEN_SIO_RST;
         PH_SIO_RST_REL:  len = LEN_SIO_RST_REL;
         PH_SIO_RST_LOW2: len = LEN_SIO_LOW2;
         PH_SIO_RST_REL2: len = LEN_SIO_REL2;
         PH_SIO_SS:       len = LEN_SIO_SS;
         PH_SIO_BIT_LOW:  len = (slot_read || slot_val) ? LEN_SIO_SHORT : LEN_SIO_W0_LOW;
         PH_SIO_BIT_REL:  len = slot_read ? LEN_SIO_RD_REL :
                                (slot_val ? LEN_SIO_W1_REL : LEN_SIO_W0_REL);
         default:         len = LEN_ONE;
      endcase
   end

   assign tick_next = {1'b0, cur_tick} + 10'd1;
   assign phase_end = (tick_next >= len);
   assign bit_next  = cur_bit + 4'd1;
   assign drives    = cur_phase inside {PH_OW_RST_LOW, PH_OW_RD_LOW, PH_OW_WR_LOW,
                                        PH_SIO_RST_LOW, PH_SIO_RST_LOW2, PH_SIO_BIT_LOW};

   // Advance tick, phase and slot
   always_comb begin
      phase_in = cur_phase;
      tick_in  = tick_next[8:0];
      bit_in   = cur_bit;
      done     = 1'b0;
      if (phase_end) begin
         tick_in = '0;
         case (cur_phase)
            PH_OW_RST_LOW:   phase_in = PH_OW_RST_REL;
            PH_OW_RD_LOW:    phase_in = PH_OW_RD_REL;
            PH_OW_WR_LOW:    phase_in = PH_OW_WR_REL;
            PH_SIO_RST_LOW:  phase_in = PH_SIO_RST_REL;
            PH_SIO_RST_REL:  phase_in = PH_SIO_RST_LOW2;
            PH_SIO_RST_LOW2: phase_in = PH_SIO_RST_REL2;
            PH_SIO_BIT_LOW:  phase_in = PH_SIO_BIT_REL;
            PH_SIO_BIT_REL:  begin
               bit_in = bit_next;
               if (bit_next < slots) begin
                  phase_in = PH_SIO_BIT_LOW;
               end else begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         endcase
      end
      cmd_in  = cur_cmd;
      nack_in = cur_nack;
   end

   // Build the tick result
   always_comb begin
      result = '0;
      if (no_work) begin
         result = '0;
      end else if (immediate) begin
         result.done_res = 1'b1;
         result.flag     = (cur_cmd == FUNC_READ_BYTE);
      end else begin
         result.drive_low = drives;
         result.busy_res  = ~done;
         result.done_res  = done;
         if (done) begin
            case (cur_cmd)
               FUNC_RESET, FUNC_READ_BIT: result.flag = samp_in;
               FUNC_READ_BYTE: begin
                  result.flag     = 1'b1;
                  result.data_out = shift_in;
               end
               FUNC_WRITE_BYTE: result.flag = ~samp_in;
               default:         result.flag = 1'b0;
            endcase
         end
      end
   end

   // Update state once per consumed tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         shift_ff <= '0;
         bit_ff   <= '0;
         cmd_ff   <= '0;
         samp_ff  <= 1'b0;
         nack_ff  <= 1'b0;
      end else if (fire && !no_work) begin
         if (immediate) begin
            phase_ff <= PH_IDLE;
            tick_ff  <= cur_tick;
            shift_ff <= cur_shift;
            bit_ff   <= cur_bit;
            cmd_ff   <= cur_cmd;
            samp_ff  <= cur_samp;
            nack_ff  <= cur_nack;
         end else begin
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            shift_ff <= shift_in;
            bit_ff   <= bit_in;
            cmd_ff   <= cmd_in;
            samp_ff  <= samp_in;
            nack_ff  <= nack_in;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/swb_rsp_reg.sv
// Result register stage: holds one result item until the consumer takes it.
`default_nettype none
module swb_rsp_reg
   import swb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type load_item,
   output logic         space,
   output logic         rsp_valid,
   output rsp_type      rsp_item,
   input  wire logic    rsp_stall
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type item_ff;

   // Room when empty or the held item leaves this edge
   assign space = ~valid_ff | ~rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture result payload
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule
`default_nettype wire

// File: rtl/single_wire_bus_master.sv
// A tick item held in the input stage moves through the engine into the result stage when that stage has room.
// Throughput: one tick item per cycle while the result side does not stall.
// Each accepted tick item yields exactly one result item.
// Reset (synchronous, active high) empties both stages, returns the engine to idle
// and sets the line mode to one-wire timing.
`default_nettype none
module single_wire_bus_master
   import swb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire req_type    req_item,
   output logic            req_stall,
   output logic            rsp_valid,
   output rsp_type         rsp_item,
   input  wire logic       rsp_stall,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_wdata
);

   logic       hold_valid;
   req_type    hold_item;
   logic       space;
   logic       take;
   rsp_type    result;
   logic [1:0] mode_ff;
   logic [1:0] mode_in;

   // Line mode register
   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? csr_wdata : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ONE_WIRE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Move an item from the input stage to the result stage
   assign take = hold_valid & space;

   swb_req_reg u_req (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .req_stall  (req_stall),
      .take       (take),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   swb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (take),
      .item      (hold_item),
      .line_mode (mode_ff),
      .result    (result)
   );

   swb_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .load_item (result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_stall (rsp_stall)
   );

endmodule
`default_nettype wire

// File: rtl/swb_checker.sv
// Port-level checks for the single-wire bus master, bound to the top level.
`default_nettype none
module swb_checker
   import swb_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_item,
   input wire logic    rsp_stall
);

   // Reset empties the result stage
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // Done and busy never together
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.done_res |-> !rsp_item.busy_res)
      else $error("done with busy");

   // Flag and data only at done
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.done_res |-> !rsp_item.flag && rsp_item.data_out == 8'd0)
      else $error("flag or data without done");

   // Driving low never ends a command
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.drive_low |-> rsp_item.busy_res)
      else $error("drive low outside a running command");

endmodule

bind single_wire_bus_master swb_checker u_swb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item),
   .rsp_stall (rsp_stall)
);
`default_nettype wire

// File: tb/swb_line_checker.sv
// Checker for the single-wire bus master: tracks accepted tick items and compares result items.
module swb_line_checker
   import swb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_item,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_item,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [1:0] csr_wdata,
   output int         mismatch_count,
   output int         pending_count
);

   // Own copy of the engine state and the mode register
   phase_type  eng_phase;
   logic [8:0] eng_ticks;
   logic [7:0] eng_shift;
   logic [3:0] eng_slot;
   logic [2:0] eng_cmd;
   logic       eng_sample;
   logic       eng_nack;
   logic [1:0] line_mode_q;

   // Expected result items, oldest first
   rsp_type    line_results_q[$];
   rsp_type    want;

   // Slot of a byte or bit command that samples the line instead of driving data
   function automatic logic slot_reads();
      case (eng_cmd)
         FUNC_READ_BIT:   return 1'b1;
         FUNC_READ_BYTE:  return eng_slot < 4'd8;
         FUNC_WRITE_BYTE: return eng_slot >= 4'd8;
         default:         return 1'b0;
      endcase
   endfunction

   // Bit sent in the current slot: write bit, ACK/NACK after a read, or byte MSB first
   function automatic logic slot_value();
      case (eng_cmd)
         FUNC_WRITE_BIT:  return eng_shift[0];
         FUNC_READ_BYTE:  return eng_nack;
         FUNC_WRITE_BYTE: return (eng_slot < 4'd8) ? eng_shift[3'd7 - eng_slot[2:0]] : 1'b0;
         default:         return 1'b0;
      endcase
   endfunction

   // Length of the current phase in ticks
   function automatic int phase_ticks();
      case (eng_phase)
         PH_OW_RST_LOW, PH_OW_RST_REL: return 480;
         PH_OW_RD_LOW:    return 6;
         PH_OW_RD_REL:    return 61;
         PH_OW_WR_LOW:    return eng_shift[0] ? 6 : 60;
         PH_OW_WR_REL:    return eng_shift[0] ? 64 : 10;
         PH_SIO_RST_LOW:  return 480;
         PH_SIO_RST_REL:  return 10;
         PH_SIO_RST_LOW2: return 2;
         PH_SIO_RST_REL2: return 3;
         PH_SIO_SS:       return 150;
         PH_SIO_BIT_LOW:  return (slot_reads() || slot_value()) ? 1 : 6;
         PH_SIO_BIT_REL:  return slot_reads() ? 10 : (slot_value() ? 12 : 7);
         default:         return 1;
      endcase
   endfunction

   // Capture the line at the sample point of the current phase
   function automatic void sample_line(input logic level);
      if ((eng_phase == PH_OW_RST_REL && eng_ticks == 9'd70) ||
          (eng_phase == PH_OW_RD_REL && eng_ticks == 9'd6) ||
          (eng_phase == PH_SIO_RST_REL2 && eng_ticks == 9'd2)) begin
         eng_sample = level;
      end else if (eng_phase == PH_SIO_BIT_REL && eng_ticks == 9'd0 && slot_reads()) begin
         eng_sample = level;
         if (eng_cmd == FUNC_READ_BYTE && eng_slot < 4'd8) begin
            eng_shift = {eng_shift[6:0], level};
         end
      end
   endfunction

   // Move to the next phase; returns 1 when the command is complete
   function automatic logic advance_phase();
      eng_ticks = '0;
      case (eng_phase)
         PH_OW_RST_LOW:   eng_phase = PH_OW_RST_REL;
         PH_OW_RD_LOW:    eng_phase = PH_OW_RD_REL;
         PH_OW_WR_LOW:    eng_phase = PH_OW_WR_REL;
         PH_SIO_RST_LOW:  eng_phase = PH_SIO_RST_REL;
         PH_SIO_RST_REL:  eng_phase = PH_SIO_RST_LOW2;
         PH_SIO_RST_LOW2: eng_phase = PH_SIO_RST_REL2;
         PH_SIO_BIT_LOW:  eng_phase = PH_SIO_BIT_REL;
         PH_SIO_BIT_REL: begin
            eng_slot = eng_slot + 4'd1;
            if (eng_slot < ((eng_cmd == FUNC_READ_BYTE || eng_cmd == FUNC_WRITE_BYTE) ?
                            4'd9 : 4'd1)) begin
               eng_phase = PH_SIO_BIT_LOW;
               return 1'b0;
            end
            eng_phase = PH_IDLE;
            return 1'b1;
         end
         default: begin
            eng_phase = PH_IDLE;
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   // Work out the result item of one tick and advance the engine copy
   function automatic rsp_type predict_line_tick(input req_type t);
      rsp_type o;
      logic    fin;
      logic    drv;
      o = '0;
      if (eng_phase == PH_IDLE) begin
         if (!t.start_req) return o;
         eng_cmd    = t.func;
         eng_ticks  = '0;
         eng_slot   = '0;
         eng_sample = 1'b0;
         eng_shift  = '0;
         case (line_mode_q)
            MODE_ONE_WIRE: begin
               case (t.func)
                  FUNC_RESET:    eng_phase = PH_OW_RST_LOW;
                  FUNC_READ_BIT: eng_phase = PH_OW_RD_LOW;
                  FUNC_WRITE_BIT: begin
                     eng_phase = PH_OW_WR_LOW;
                     eng_shift = {7'd0, t.data_in[0]};
                  end
                  default: ;
               endcase
            end
            MODE_SIO: begin
               case (t.func)
                  FUNC_RESET:    eng_phase = PH_SIO_RST_LOW;
                  FUNC_READ_BIT: eng_phase = PH_SIO_BIT_LOW;
                  FUNC_WRITE_BIT: begin
                     eng_phase = PH_SIO_BIT_LOW;
                     eng_shift = {7'd0, t.data_in[0]};
                  end
                  FUNC_READ_BYTE: begin
                     eng_phase = PH_SIO_BIT_LOW;
                     eng_nack  = t.last_byte;
                  end
                  FUNC_WRITE_BYTE: begin
                     eng_phase = PH_SIO_BIT_LOW;
                     eng_shift = t.data_in;
                  end
                  FUNC_START_STOP: eng_phase = PH_SIO_SS;
                  default: ;
               endcase
            end
            default: ;
         endcase
         // Commands with no waveform finish on the start tick
         if (eng_phase == PH_IDLE) begin
            o.done_res = 1'b1;
            o.flag     = (t.func == FUNC_READ_BYTE);
            return o;
         end
      end
      drv = eng_phase inside {PH_OW_RST_LOW, PH_OW_RD_LOW, PH_OW_WR_LOW,
                              PH_SIO_RST_LOW, PH_SIO_RST_LOW2, PH_SIO_BIT_LOW};
      sample_line(t.line_level);
      if (int'(eng_ticks) + 1 >= phase_ticks()) begin
         fin = advance_phase();
      end else begin
         eng_ticks = eng_ticks + 9'd1;
         fin = 1'b0;
      end
      if (fin) begin
         case (eng_cmd)
            FUNC_RESET, FUNC_READ_BIT: o.flag = eng_sample;
            FUNC_READ_BYTE: begin
               o.flag     = 1'b1;
               o.data_out = eng_shift;
            end
            FUNC_WRITE_BYTE: o.flag = ~eng_sample;
            default: ;
         endcase
      end
      o.drive_low = drv;
      o.busy_res  = ~fin;
      o.done_res  = fin;
      return o;
   endfunction

   // Count a bad result item and print the first few
   task automatic report_bad(input string what, input rsp_type exp_r, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected drive %0b busy %0b done %0b flag %0b data %02h, got drive %0b busy %0b done %0b flag %0b data %02h",
                  what, exp_r.drive_low, exp_r.busy_res, exp_r.done_res, exp_r.flag,
                  exp_r.data_out, got.drive_low, got.busy_res, got.done_res, got.flag,
                  got.data_out);
      end
   endtask

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   // Compare results, then predict new items, then track register writes
   always @(posedge clock) begin
      if (reset) begin
         eng_phase   = PH_IDLE;
         eng_ticks   = '0;
         eng_shift   = '0;
         eng_slot    = '0;
         eng_cmd     = '0;
         eng_sample  = 1'b0;
         eng_nack    = 1'b0;
         line_mode_q = MODE_ONE_WIRE;
         line_results_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (line_results_q.size() == 0) begin
               report_bad("result item with nothing expected", '0, rsp_item);
            end else begin
               want = line_results_q.pop_front();
               if (rsp_item.drive_low !== want.drive_low ||
                   rsp_item.busy_res !== want.busy_res ||
                   rsp_item.done_res !== want.done_res ||
                   rsp_item.flag !== want.flag ||
                   rsp_item.data_out !== want.data_out) begin
                  report_bad("result item mismatch", want, rsp_item);
               end
            end
         end
         if (req_valid && !req_stall) begin
            line_results_q.push_back(predict_line_tick(req_item));
         end
         if (csr_valid && csr_ready) begin
            line_mode_q = csr_wdata;
         end
      end
      pending_count = line_results_q.size();
   end

endmodule

// File: tb/tb_top.sv
// Top of the single-wire bus master bench: clock, reset, tick stimulus and verdict.
module tb_top;
   import swb_pkg::*;

   localparam logic [2:0] FUNC_UNDEF_6 = 3'd6;
   localparam logic [2:0] FUNC_UNDEF_7 = 3'd7;
   localparam logic [1:0] MODE_UNDEF   = 2'd3;
   localparam int IDLE_PCT     = 32;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 20000;
   localparam int ITEM_TARGET  = 760;
   localparam int PHASE_CMDS   = 4;

   logic       clock;
   logic       reset;
   logic       req_valid;
   req_type    req_item;
   logic       req_stall;
   logic       rsp_valid;
   rsp_type    rsp_item;
   logic       rsp_stall = 1'b0;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_wdata;

   int         mismatch_count;
   int         pending_count;
   int         ticks_sent;
   int         results_seen;
   int         done_seen;
   int         commands_issued;
   int         mode_writes;
   int         cycle_count;
   logic       calm;
   logic [1:0] mode_now;

   single_wire_bus_master i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   swb_line_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Stall the result side at random, except in the calm stretch
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   // Count results and completed commands; stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_item.done_res) done_seen++;
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Random tick item; a start request only where allowed
   function automatic req_type random_tick(input logic may_start);
      req_type t;
      t.start_req  = may_start && ($urandom_range(2) == 0);
      t.func       = $urandom_range(7);
      t.data_in    = $urandom_range(255);
      t.last_byte  = $urandom_range(1);
      t.line_level = $urandom_range(1);
      return t;
   endfunction

   // Offer one tick item and hold it until accepted
   task automatic send_tick(input req_type t);
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   // Start one command, then tick the bus until its done result comes back
   // or the tick budget runs out
   task automatic run_command(input logic [2:0] fn, input logic [7:0] data, input logic last);
      req_type t;
      int      k;
      logic    long_cmd;
      if (ticks_sent >= ITEM_TARGET) return;
      t = random_tick(1'b0);
      t.start_req = 1'b1;
      t.func      = fn;
      t.data_in   = data;
      t.last_byte = last;
      long_cmd = (mode_now == MODE_ONE_WIRE && fn <= FUNC_WRITE_BIT) ||
                 (mode_now == MODE_SIO && fn <= FUNC_START_STOP);
      commands_issued++;
      send_tick(t);
      // starts within the shortest slot of a running command must be ignored
      k = 0;
      while (done_seen < commands_issued && ticks_sent < ITEM_TARGET) begin
         send_tick(random_tick(long_cmd && k < 10));
         k++;
      end
   endtask

   // Drain the pipe, then write the mode register
   task automatic write_mode(input logic [1:0] m);
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_seen != ticks_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      mode_now = m;
      mode_writes++;
   endtask

   // Mostly plain commands, a few bus resets and undefined codes
   function automatic logic [2:0] pick_func();
      int r;
      r = $urandom_range(99);
      if (r < 4) return FUNC_RESET;
      if (r < 6) return FUNC_UNDEF_6;
      if (r < 8) return FUNC_UNDEF_7;
      return 3'($urandom_range(int'(FUNC_START_STOP), int'(FUNC_READ_BIT)));
   endfunction

   function automatic logic [1:0] pick_mode();
      int r;
      r = $urandom_range(9);
      if (r < 4) return MODE_ONE_WIRE;
      if (r < 8) return MODE_SIO;
      if (r == 8) return MODE_SINGLE;
      return MODE_UNDEF;
   endfunction

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_item        = '0;
      csr_valid       = 1'b0;
      csr_wdata       = '0;
      calm            = 1'b0;
      mode_now        = MODE_ONE_WIRE;
      ticks_sent      = 0;
      results_seen    = 0;
      done_seen       = 0;
      commands_issued = 0;
      mode_writes     = 0;
      cycle_count     = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // One-wire bit slots and the commands it completes at once
      write_mode(MODE_ONE_WIRE);
      run_command(FUNC_READ_BIT, 8'hFF, 1'b1);
      run_command(FUNC_WRITE_BIT, 8'h00, 1'b0);
      run_command(FUNC_WRITE_BIT, 8'hFF, 1'b1);
      run_command(FUNC_READ_BYTE, 8'h00, 1'b1);
      run_command(FUNC_WRITE_BYTE, 8'hFF, 1'b0);
      run_command(FUNC_START_STOP, 8'h00, 1'b0);
      run_command(FUNC_UNDEF_7, 8'hFF, 1'b1);

      // SIO bit slots, ACK and NACK after a read, a mixed byte write
      write_mode(MODE_SIO);
      run_command(FUNC_READ_BIT, 8'h00, 1'b0);
      run_command(FUNC_WRITE_BIT, 8'h00, 1'b0);
      run_command(FUNC_WRITE_BIT, 8'h01, 1'b1);
      run_command(FUNC_UNDEF_6, 8'h5A, 1'b0);
      run_command(FUNC_READ_BYTE, 8'hFF, 1'b0);
      // Byte traffic back to back with no idling on either side
      calm = 1'b1;
      run_command(FUNC_READ_BYTE, 8'h00, 1'b1);
      run_command(FUNC_WRITE_BYTE, 8'hA5, 1'b0);
      calm = 1'b0;

      // Single-wire and the undefined mode finish everything at once
      write_mode(MODE_SINGLE);
      run_command(FUNC_RESET, 8'h00, 1'b0);
      run_command(FUNC_WRITE_BYTE, 8'hA5, 1'b1);
      run_command(FUNC_READ_BYTE, 8'h3C, 1'b0);
      write_mode(MODE_UNDEF);
      run_command(FUNC_READ_BIT, 8'hFF, 1'b1);
      run_command(FUNC_UNDEF_7, 8'h00, 1'b0);

      // Random commands in short phases of one mode each until the tick budget is spent
      while (ticks_sent < ITEM_TARGET) begin
         write_mode(pick_mode());
         for (int c = 0; c < PHASE_CMDS && ticks_sent < ITEM_TARGET; c++) begin
            run_command(pick_func(), 8'($urandom_range(255)), 1'($urandom_range(1)));
         end
      end

      // Drain and settle
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_seen != ticks_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d commands over %0d tick items with %0d mode register writes",
               commands_issued, ticks_sent, mode_writes);
      $display("checked %0d result items, %0d command completions",
               results_seen, done_seen);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
